/* src/oulist_pkg.sv */
// Shared types and constants for the ordered unique value list.
// Holds field widths, operation and status codes, FSM state type and the
// command/status bundles between controller and datapath.
package oulist_pkg;

  localparam int MODE_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_LIST   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_SHIFT  = 5'b01000,
    S_LIST   = 5'b10000
  } state_t;

  typedef struct packed {
    logic accept;
    logic scan_en;
    logic decide_load;
    logic shift_start;
    logic shift_en;
    logic shift_finish;
    logic list_en;
    logic list_empty_load;
  } cmd_t;

  typedef struct packed {
    logic scan_end;
    logic found;
    logic is_delete;
    logic shift_end;
    logic out_free;
    logic count_zero;
    logic list_end;
  } sts_t;

endpackage

/* src/ordered_unique_value_list.sv */
// Ordered unique value list, one item at a time.
// Insert, search and delete scan the stored entries from the head, then register
// one result word; a delete hit first shifts the later entries down. List gives
// a single empty word or one word per entry, one per cycle while the output is free.
// Next item accepted the cycle after the last word is loaded.
// Reset clears the count and output valid; RAM contents are not cleared.
module ordered_unique_value_list #(
  parameter int CAPACITY = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [oulist_pkg::MODE_W-1:0]       in_mode,
  input  logic signed [oulist_pkg::VALUE_W-1:0] in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [oulist_pkg::STATUS_W-1:0]     out_status,
  output logic signed [oulist_pkg::VALUE_W-1:0] out_entry_value,
  output logic [oulist_pkg::POS_W-1:0]        out_position,
  output logic [oulist_pkg::COUNT_W-1:0]      out_entry_count,
  output logic                                out_last
);
  import oulist_pkg::*;

  cmd_t cmd;
  sts_t sts;

  oulist_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  oulist_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mode         (in_mode),
    .in_value        (in_value),
    .out_ready       (out_ready),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_entry_value (out_entry_value),
    .out_position    (out_position),
    .out_entry_count (out_entry_count),
    .out_last        (out_last)
  );

  // at most one result source or an accept in any cycle
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.accept, cmd.decide_load, cmd.shift_finish, cmd.list_empty_load,
              cmd.list_en && sts.list_end}))
    else $error("conflicting result commands");

  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |-> (out_last && out_entry_count == '0))
    else $error("empty word must be single and report zero count");

  a_mid_list_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (out_status == ST_OK))
    else $error("non-final word must be a listed entry");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan_en || cmd.shift_en || cmd.list_en) |-> !in_ready)
    else $error("input taken while an operation is in flight");

endmodule

/* src/oulist_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Read data holds when no read is enabled. No dependencies.
module oulist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* src/oulist_ctrl.sv */
// Controller FSM of the ordered unique value list.
// Depends on oulist_pkg; drives datapath commands from datapath status.
module oulist_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic [oulist_pkg::MODE_W-1:0]     in_mode,
  output logic                              in_ready,
  input  oulist_pkg::sts_t                  sts,
  output oulist_pkg::cmd_t                  cmd
);
  import oulist_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = (in_mode == MODE_LIST) ? S_LIST : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (sts.scan_end) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.found && sts.is_delete) begin
          cmd.shift_start = 1'b1;
          state_nxt       = S_SHIFT;
        end else if (sts.out_free) begin
          cmd.decide_load = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_SHIFT: begin
        cmd.shift_en = 1'b1;
        // close the gap first, then report
        if (sts.shift_end && sts.out_free) begin
          cmd.shift_finish = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      S_LIST: begin
        if (sts.count_zero) begin
          if (sts.out_free) begin
            cmd.list_empty_load = 1'b1;
            state_nxt           = S_IDLE;
          end
        end else begin
          cmd.list_en = 1'b1;
          if (sts.list_end) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* src/oulist_dp.sv */
// Datapath of the ordered unique value list: entry RAM, scan pointer,
// compare, count and the output word register. Depends on oulist_pkg, oulist_ram.
module oulist_dp #(
  parameter int CAPACITY = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [oulist_pkg::MODE_W-1:0]       in_mode,
  input  logic [oulist_pkg::VALUE_W-1:0]      in_value,
  input  logic                                out_ready,
  input  oulist_pkg::cmd_t                    cmd,
  output oulist_pkg::sts_t                    sts,
  output logic                                out_valid,
  output logic [oulist_pkg::STATUS_W-1:0]     out_status,
  output logic [oulist_pkg::VALUE_W-1:0]      out_entry_value,
  output logic [oulist_pkg::POS_W-1:0]        out_position,
  output logic [oulist_pkg::COUNT_W-1:0]      out_entry_count,
  output logic                                out_last
);
  import oulist_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [MODE_W-1:0]   mode_r, mode_nxt;
  logic [VALUE_W-1:0]  value_r, value_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       rp_r, rp_nxt;
  logic                dv_r, dv_nxt;
  logic [IW-1:0]       di_r, di_nxt;
  logic                found_r, found_nxt;
  logic [IW-1:0]       pos_r, pos_nxt;

  logic                out_vld_r, out_vld_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [VALUE_W-1:0]  out_value_r, out_value_nxt;
  logic [POS_W-1:0]    out_pos_r, out_pos_nxt;
  logic [COUNT_W-1:0]  out_count_r, out_count_nxt;
  logic                out_last_r, out_last_nxt;

  logic                ram_wr_en;
  logic [IW-1:0]       ram_wr_addr;
  logic [VALUE_W-1:0]  ram_wr_data;
  logic                ram_rd_en;
  logic [VALUE_W-1:0]  ram_rd_data;

  logic match, more, out_free, full;
  logic scan_issue, shift_issue, list_issue, list_load, list_last;

  oulist_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (rp_r[IW-1:0]),
    .rd_data (ram_rd_data)
  );

  assign match       = dv_r && (ram_rd_data == value_r);
  assign more        = rp_r < count_r;
  assign full        = count_r == CAP_C;
  assign out_free    = !out_vld_r || out_ready;
  assign scan_issue  = cmd.scan_en && !match && more;
  assign shift_issue = cmd.shift_en && more;
  assign list_load   = cmd.list_en && dv_r && out_free;
  // keep one word in the RAM read register while the output is stalled
  assign list_issue  = cmd.list_en && more && (!dv_r || list_load);
  assign list_last   = list_load &&
                       ((CW + 1)'(di_r) + (CW + 1)'(1) == (CW + 1)'(count_r));

  always_comb begin
    sts            = '0;
    sts.scan_end   = match || (!dv_r && !more);
    sts.found      = found_r;
    sts.is_delete  = mode_r == MODE_DELETE;
    sts.shift_end  = !dv_r && !more;
    sts.out_free   = out_free;
    sts.count_zero = count_r == '0;
    sts.list_end   = list_last;
  end

  always_comb begin
    mode_nxt       = mode_r;
    value_nxt      = value_r;
    count_nxt      = count_r;
    rp_nxt         = rp_r;
    dv_nxt         = dv_r;
    di_nxt         = di_r;
    found_nxt      = found_r;
    pos_nxt        = pos_r;
    out_vld_nxt    = out_vld_r && !out_ready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_pos_nxt    = out_pos_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = count_r[IW-1:0];
    ram_wr_data    = value_r;
    ram_rd_en      = 1'b0;

    if (cmd.accept) begin
      mode_nxt  = in_mode;
      value_nxt = in_value;
      rp_nxt    = '0;
      dv_nxt    = 1'b0;
      found_nxt = 1'b0;
      pos_nxt   = '0;
    end

    if (cmd.scan_en) begin
      ram_rd_en = scan_issue;
      dv_nxt    = scan_issue;
      if (scan_issue) begin
        rp_nxt = rp_r + CW'(1);
        di_nxt = rp_r[IW-1:0];
      end
      if (match) begin
        found_nxt = 1'b1;
        pos_nxt   = di_r;
      end
    end

    if (cmd.decide_load) begin
      out_vld_nxt   = 1'b1;
      out_value_nxt = value_r;
      out_count_nxt = COUNT_W'(count_r);
      out_last_nxt  = 1'b1;
      out_pos_nxt   = '0;
      if (found_r) begin
        out_status_nxt = (mode_r == MODE_INSERT) ? ST_DUPLICATE : ST_OK;
        out_pos_nxt    = POS_W'(pos_r);
      end else if (mode_r == MODE_INSERT) begin
        if (full) begin
          out_status_nxt = ST_FULL;
        end else begin
          // append at the tail
          ram_wr_en      = 1'b1;
          count_nxt      = count_r + CW'(1);
          out_status_nxt = ST_OK;
          out_pos_nxt    = POS_W'(count_r);
          out_count_nxt  = COUNT_W'(count_r + CW'(1));
        end
      end else begin
        out_status_nxt = ST_NOT_FOUND;
      end
    end

    if (cmd.shift_start) begin
      rp_nxt = CW'(pos_r) + CW'(1);
      dv_nxt = 1'b0;
    end

    if (cmd.shift_en) begin
      ram_rd_en = shift_issue;
      dv_nxt    = shift_issue;
      if (shift_issue) begin
        rp_nxt = rp_r + CW'(1);
        di_nxt = rp_r[IW-1:0];
      end
      // move each later entry down by one
      if (dv_r) begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = di_r - IW'(1);
        ram_wr_data = ram_rd_data;
      end
    end

    if (cmd.shift_finish) begin
      count_nxt      = count_r - CW'(1);
      out_vld_nxt    = 1'b1;
      out_status_nxt = ST_OK;
      out_value_nxt  = value_r;
      out_pos_nxt    = POS_W'(pos_r);
      out_count_nxt  = COUNT_W'(count_r - CW'(1));
      out_last_nxt   = 1'b1;
    end

    if (cmd.list_en) begin
      ram_rd_en = list_issue;
      dv_nxt    = list_issue || (dv_r && !list_load);
      if (list_issue) begin
        rp_nxt = rp_r + CW'(1);
        di_nxt = rp_r[IW-1:0];
      end
      if (list_load) begin
        out_vld_nxt    = 1'b1;
        out_status_nxt = ST_OK;
        out_value_nxt  = ram_rd_data;
        out_pos_nxt    = POS_W'(di_r);
        out_count_nxt  = COUNT_W'(count_r);
        out_last_nxt   = list_last;
      end
    end

    if (cmd.list_empty_load) begin
      out_vld_nxt    = 1'b1;
      out_status_nxt = ST_EMPTY;
      out_value_nxt  = '0;
      out_pos_nxt    = '0;
      out_count_nxt  = '0;
      out_last_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      dv_r      <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      dv_r      <= dv_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    value_r      <= value_nxt;
    rp_r         <= rp_nxt;
    di_r         <= di_nxt;
    found_r      <= found_nxt;
    pos_r        <= pos_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_pos_r    <= out_pos_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid       = out_vld_r;
  assign out_status      = out_status_r;
  assign out_entry_value = out_value_r;
  assign out_position    = out_pos_r;
  assign out_entry_count = out_count_r;
  assign out_last        = out_last_r;

endmodule

/* tb/oulist_checker.sv */
// Checker for the ordered unique value list: watches both channels, keeps a
// shadow copy of the stored values and compares every result word in order.
// Depends on oulist_pkg for field widths, operation and status codes.
module oulist_checker
  import oulist_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [MODE_W-1:0]   in_mode,
  input  logic [VALUE_W-1:0]  in_value,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [STATUS_W-1:0] out_status,
  input  logic [VALUE_W-1:0]  out_entry_value,
  input  logic [POS_W-1:0]    out_position,
  input  logic [COUNT_W-1:0]  out_entry_count,
  input  logic                out_last,
  output int unsigned         fail_count,
  output int unsigned         pending_words,
  output int unsigned         words_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  value;
    logic [POS_W-1:0]    position;
    logic [COUNT_W-1:0]  count;
    logic                last;
  } list_word_t;

  logic [VALUE_W-1:0] shadow_entries[$];
  list_word_t         expected_words[$];
  int unsigned        errors  = 0;
  int unsigned        checked = 0;

  function automatic void push_word(input logic [STATUS_W-1:0] status,
                                    input logic [VALUE_W-1:0] value,
                                    input logic [POS_W-1:0] position,
                                    input logic [COUNT_W-1:0] count,
                                    input logic last);
    list_word_t w;
    w.status   = status;
    w.value    = value;
    w.position = position;
    w.count    = count;
    w.last     = last;
    expected_words.push_back(w);
  endfunction

  // Update the shadow list for one accepted word and queue its results.
  function automatic void apply_list_op(input logic [MODE_W-1:0] op,
                                        input logic [VALUE_W-1:0] val);
    int hit;
    int n;
    hit = -1;
    n   = shadow_entries.size();
    for (int i = 0; i < n; i++) begin
      if (hit < 0 && shadow_entries[i] == val) hit = i;
    end
    case (op)
      MODE_INSERT: begin
        if (hit >= 0) begin
          push_word(ST_DUPLICATE, val, POS_W'(hit), COUNT_W'(n), 1'b1);
        end else if (n >= CAPACITY) begin
          push_word(ST_FULL, val, '0, COUNT_W'(n), 1'b1);
        end else begin
          shadow_entries.push_back(val);
          push_word(ST_OK, val, POS_W'(n), COUNT_W'(n + 1), 1'b1);
        end
      end
      MODE_SEARCH: begin
        if (hit >= 0) push_word(ST_OK, val, POS_W'(hit), COUNT_W'(n), 1'b1);
        else push_word(ST_NOT_FOUND, val, '0, COUNT_W'(n), 1'b1);
      end
      MODE_DELETE: begin
        if (hit >= 0) begin
          shadow_entries.delete(hit);
          push_word(ST_OK, val, POS_W'(hit), COUNT_W'(n - 1), 1'b1);
        end else begin
          push_word(ST_NOT_FOUND, val, '0, COUNT_W'(n), 1'b1);
        end
      end
      default: begin
        if (n == 0) begin
          push_word(ST_EMPTY, '0, '0, '0, 1'b1);
        end else begin
          for (int i = 0; i < n; i++) begin
            push_word(ST_OK, shadow_entries[i], POS_W'(i), COUNT_W'(n), (i == n - 1));
          end
        end
      end
    endcase
  endfunction

  always @(posedge clk) begin
    list_word_t want;
    if (!rst_n) begin
      shadow_entries.delete();
      expected_words.delete();
    end else begin
      // Results from earlier words leave before this edge's word is predicted.
      if (out_valid && out_ready) begin
        checked++;
        if (expected_words.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected result word: status %0d value %h pos %0d count %0d last %0b",
                     out_status, out_entry_value, out_position, out_entry_count,
                     out_last);
          end
        end else begin
          want = expected_words.pop_front();
          if (want.status !== out_status || want.value !== out_entry_value ||
              want.position !== out_position || want.count !== out_entry_count ||
              want.last !== out_last) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch expected: status %0d value %h pos %0d count %0d last %0b",
                       want.status, want.value, want.position, want.count, want.last);
              $display("         actual:   status %0d value %h pos %0d count %0d last %0b",
                       out_status, out_entry_value, out_position, out_entry_count,
                       out_last);
            end
          end
        end
      end
      if (in_valid && in_ready) apply_list_op(in_mode, in_value);
    end
    fail_count    <= errors;
    pending_words <= expected_words.size();
    words_checked <= checked;
  end

endmodule

/* tb/testbench.sv */
// Top of the ordered unique value list testbench: clock, reset, stimulus and
// receiver flow control; checking is done by oulist_checker beside the block.
// Depends on oulist_pkg, ordered_unique_value_list and oulist_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import oulist_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int CAPACITY      = 16;
  localparam int RANDOM_ITEMS  = 233;
  localparam int POOL_SIZE     = 24;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 1_000_000;

  typedef enum int unsigned {PH_FILL, PH_CHURN, PH_DRAIN} phase_kind_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [MODE_W-1:0]   in_mode;
  logic [VALUE_W-1:0]  in_value;
  logic                out_valid;
  logic                out_ready;
  logic [STATUS_W-1:0] out_status;
  logic [VALUE_W-1:0]  out_entry_value;
  logic [POS_W-1:0]    out_position;
  logic [COUNT_W-1:0]  out_entry_count;
  logic                out_last;

  int unsigned fail_count;
  int unsigned pending_words;
  int unsigned words_checked;

  logic               tx_steady   = 1'b0;
  logic               rx_steady   = 1'b0;
  logic               rx_hold_req = 1'b0;
  int unsigned        mode_tally[4] = '{default: 0};
  int unsigned        cycle_count = 0;
  logic [VALUE_W-1:0] value_pool[POOL_SIZE];

  always #(CLK_PERIOD / 2) clk = ~clk;

  ordered_unique_value_list #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_entry_value(out_entry_value),
    .out_position   (out_position),
    .out_entry_count(out_entry_count),
    .out_last       (out_last)
  );

  oulist_checker #(
    .CAPACITY(CAPACITY)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_entry_value(out_entry_value),
    .out_position   (out_position),
    .out_entry_count(out_entry_count),
    .out_last       (out_last),
    .fail_count     (fail_count),
    .pending_words  (pending_words),
    .words_checked  (words_checked)
  );

  // Mostly no gap, some short ones, a few long ones.
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(input logic [MODE_W-1:0] mode_v,
                           input logic [VALUE_W-1:0] val_v);
    int unsigned gap;
    in_valid <= 1'b1;
    in_mode  <= mode_v;
    in_value <= val_v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    mode_tally[mode_v]++;
    gap = tx_steady ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold the sender until every expected word has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
  endtask

  // Receiver flow control.
  initial begin
    int unsigned gap;
    out_ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!rx_steady) begin
        gap = idle_len();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               pending_words);
      $display("[ordered_unique_value_list] ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned   random_sent;
    int unsigned   phase_idx;
    int unsigned   len;
    int unsigned   roll;
    int unsigned   ins_cut;
    int unsigned   srch_cut;
    int unsigned   del_cut;
    phase_kind_t   kind;
    logic [MODE_W-1:0]  op;
    logic [VALUE_W-1:0] val;

    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_mode  <= MODE_INSERT;
    in_value <= '0;

    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7FFF_FFFF;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty store, extremes, duplicate, head delete, full, tail delete.
    send_item(MODE_LIST, 32'h0);
    send_item(MODE_SEARCH, value_pool[0]);
    send_item(MODE_DELETE, value_pool[0]);
    for (int i = 0; i < 4; i++) send_item(MODE_INSERT, value_pool[i]);
    send_item(MODE_INSERT, value_pool[1]);
    send_item(MODE_SEARCH, value_pool[2]);
    send_item(MODE_LIST, 32'hFFFF_FFFF);
    send_item(MODE_DELETE, value_pool[0]);
    for (int i = 4; i < 4 + CAPACITY - 3; i++) send_item(MODE_INSERT, value_pool[i]);
    send_item(MODE_INSERT, value_pool[POOL_SIZE - 1]);
    send_item(MODE_LIST, 32'h5A5A_A5A5);
    send_item(MODE_DELETE, value_pool[CAPACITY]);
    wait_drained();

    random_sent = 0;
    phase_idx   = 0;
    while (random_sent < RANDOM_ITEMS) begin
      kind      = phase_kind_t'(phase_idx % 3);
      tx_steady = (phase_idx % 4 == 2);
      rx_steady = (phase_idx % 4 == 2);
      if (phase_idx == 1) begin
        // Stall the receiver while lists pile up behind it.
        rx_hold_req = 1'b1;
        repeat (6) begin
          send_item(MODE_LIST, $urandom);
          random_sent++;
        end
      end
      case (kind)
        PH_FILL:  begin ins_cut = 60; srch_cut = 75; del_cut = 88; end
        PH_DRAIN: begin ins_cut = 10; srch_cut = 25; del_cut = 88; end
        default:  begin ins_cut = 30; srch_cut = 55; del_cut = 85; end
      endcase
      len = $urandom_range(25, 45);
      // trim the last phase so the run ends on the item budget
      if (random_sent >= RANDOM_ITEMS) len = 0;
      else if (len > RANDOM_ITEMS - random_sent) len = RANDOM_ITEMS - random_sent;
      repeat (len) begin
        roll = $urandom_range(0, 99);
        if (roll < ins_cut) op = MODE_INSERT;
        else if (roll < srch_cut) op = MODE_SEARCH;
        else if (roll < del_cut) op = MODE_DELETE;
        else op = MODE_LIST;
        // Mostly pool values so hits happen; the rest are random misses.
        if ($urandom_range(0, 99) < 88) val = value_pool[$urandom_range(0, POOL_SIZE - 1)];
        else val = $urandom;
        send_item(op, val);
        random_sent++;
      end
      wait_drained();
      phase_idx++;
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d words in: %0d insert, %0d search, %0d delete, %0d list",
             mode_tally[0] + mode_tally[1] + mode_tally[2] + mode_tally[3],
             mode_tally[MODE_INSERT], mode_tally[MODE_SEARCH],
             mode_tally[MODE_DELETE], mode_tally[MODE_LIST]);
    $display("%0d result words checked over %0d random phases, %0d failures",
             words_checked, phase_idx, fail_count);
    if (fail_count == 0 && pending_words == 0) begin
      $display("[ordered_unique_value_list] OK");
    end else begin
      $display("[ordered_unique_value_list] ERROR");
    end
    $finish;
  end

endmodule
